@@ sv/wlkfe_pkg.sv @@
package wlkfe_pkg;

    // Lattice and table geometry
    localparam int SPIN_AW  = 10;   // {sublattice, y, x}
    localparam int BIN_AW   = 9;
    localparam int LD_W     = 48;
    localparam int CNT_W    = 32;
    localparam int E_W      = 12;
    localparam int CFG_W    = 33;
    localparam int CNT_CTR_W = 11;

    localparam logic signed [E_W:0] E_MAX_C = 13'sd1536;
    localparam logic signed [E_W:0] E_MIN_C = -13'sd512;
    localparam logic [LD_W-1:0]  LD_ONE  = 48'h0001_0000_0000;
    localparam logic [LD_W-1:0]  LD_MAX  = 48'hFFFF_FFFF_FFFF;
    localparam logic [CNT_W-1:0] CNT_MAX = 32'hFFFF_FFFF;
    localparam logic [32:0]      Q32_ONE = 33'h1_0000_0000;
    localparam logic [E_W-1:0]   E_RESET = 12'd1536;
    localparam logic [15:0]      FF_RESET = 16'd52429;

    // Request codes
    localparam logic [2:0] REQ_FLIP  = 3'd0;
    localparam logic [2:0] REQ_WRITE = 3'd1;
    localparam logic [2:0] REQ_FLAT  = 3'd2;
    localparam logic [2:0] REQ_CLEAR = 3'd3;
    localparam logic [2:0] REQ_READ  = 3'd4;
    localparam logic [1:0] SUB_NONE  = 2'd3;

    // Config register indexes
    localparam logic REG_LMF = 1'b0;
    localparam logic REG_FF  = 1'b1;

    // Datapath operation codes
    localparam logic [4:0] OP_NOP     = 5'd0;
    localparam logic [4:0] OP_LOAD    = 5'd1;
    localparam logic [4:0] OP_INIT    = 5'd2;
    localparam logic [4:0] OP_SPIN_RD = 5'd3;
    localparam logic [4:0] OP_DELTA   = 5'd4;
    localparam logic [4:0] OP_WRITE   = 5'd5;
    localparam logic [4:0] OP_RD_GI   = 5'd6;
    localparam logic [4:0] OP_RD_GF   = 5'd7;
    localparam logic [4:0] OP_DECIDE  = 5'd8;
    localparam logic [4:0] OP_H_MUL   = 5'd9;
    localparam logic [4:0] OP_H_REC   = 5'd10;
    localparam logic [4:0] OP_H_FIX   = 5'd11;
    localparam logic [4:0] OP_SQ_MUL  = 5'd12;
    localparam logic [4:0] OP_SQ_UPD  = 5'd13;
    localparam logic [4:0] OP_ACC     = 5'd14;
    localparam logic [4:0] OP_UPD     = 5'd15;
    localparam logic [4:0] OP_UPD2    = 5'd16;
    localparam logic [4:0] OP_SUM_RD  = 5'd17;
    localparam logic [4:0] OP_THR     = 5'd18;
    localparam logic [4:0] OP_CHK_RD  = 5'd19;
    localparam logic [4:0] OP_CLR     = 5'd20;
    localparam logic [4:0] OP_BIN_RD  = 5'd21;
    localparam logic [4:0] OP_OUT     = 5'd22;

    typedef struct packed {
        logic [4:0]         op;
        logic [CNT_CTR_W-1:0] cnt;   // sweep address, neighbor select, Horner k
    } cmd_t;

    typedef struct packed {
        logic [2:0] req;
        logic [1:0] sub;
        logic       ge;     // ln g(old) >= ln g(new)
        logic       big;    // exponent argument >= 32
    } stat_t;

    // floor(2^32 / k) for the Horner divisions
    function automatic logic [32:0] recip(input logic [3:0] k);
        logic [32:0] r;
        case (k)
            4'd1:    r = 33'd4294967296;
            4'd2:    r = 33'd2147483648;
            4'd3:    r = 33'd1431655765;
            4'd4:    r = 33'd1073741824;
            4'd5:    r = 33'd858993459;
            4'd6:    r = 33'd715827882;
            4'd7:    r = 33'd613566756;
            4'd8:    r = 33'd536870912;
            4'd9:    r = 33'd477218588;
            4'd10:   r = 33'd429496729;
            4'd11:   r = 33'd390451572;
            4'd12:   r = 33'd357913941;
            default: r = 33'd0;
        endcase
        return r;
    endfunction

endpackage

@@ sv/wang_landau_kagome_flip_engine_unit.sv @@
// Channel  | Handshake            | Payload
// ---------+----------------------+---------------------------------------------
// request  | in_valid / in_stall  | req_type sublattice site_x site_y
//          |                      | spin_value uniform bin_index
// result   | out_valid / out_stall| accepted energy_out bin_log_density
//          |                      | bin_count is_flat
// config   | cfg_we               | cfg_index cfg_data
//
// Reset: a clearing pass fills spins, ln g and counts; in_stall stays high.
// One request at a time; a flip runs the Horner series and five squarings unless
// ln g(old) >= ln g(new) or exp() underflows.
// in_stall falls in the same cycle that out_valid rises. A result held by
// out_stall keeps its register and delays only the following result.
module wang_landau_kagome_flip_engine_unit import wlkfe_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [2:0]            req_type,
    input  logic [1:0]            sublattice,
    input  logic [3:0]            site_x,
    input  logic [3:0]            site_y,
    input  logic                  spin_value,
    input  logic [31:0]           uniform,
    input  logic [BIN_AW-1:0]     bin_index,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  accepted,
    output logic signed [E_W-1:0] energy_out,
    output logic [LD_W-1:0]       bin_log_density,
    output logic [CNT_W-1:0]      bin_count,
    output logic                  is_flat,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data
);

    cmd_t  cmd;
    stat_t stat;

    wlkfe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    wlkfe_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .req_type        (req_type),
        .sublattice      (sublattice),
        .site_x          (site_x),
        .site_y          (site_y),
        .spin_value      (spin_value),
        .uniform         (uniform),
        .bin_index       (bin_index),
        .accepted        (accepted),
        .energy_out      (energy_out),
        .bin_log_density (bin_log_density),
        .bin_count       (bin_count),
        .is_flat         (is_flat)
    );

endmodule

@@ sv/wlkfe_ram.sv @@
module wlkfe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ sv/wlkfe_ctrl.sv @@
module wlkfe_ctrl import wlkfe_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    output logic  out_valid,
    input  logic  out_stall,
    input  stat_t stat,
    output cmd_t  cmd
);

    localparam logic [4:0] S_INIT   = 5'd0;
    localparam logic [4:0] S_IDLE   = 5'd1;
    localparam logic [4:0] S_DISP   = 5'd2;
    localparam logic [4:0] S_SPIN   = 5'd3;
    localparam logic [4:0] S_DELTA  = 5'd4;
    localparam logic [4:0] S_WRITE  = 5'd5;
    localparam logic [4:0] S_RDI    = 5'd6;
    localparam logic [4:0] S_RDF    = 5'd7;
    localparam logic [4:0] S_WAITF  = 5'd8;
    localparam logic [4:0] S_DECIDE = 5'd9;
    localparam logic [4:0] S_HMUL   = 5'd10;
    localparam logic [4:0] S_HREC   = 5'd11;
    localparam logic [4:0] S_HFIX   = 5'd12;
    localparam logic [4:0] S_SQMUL  = 5'd13;
    localparam logic [4:0] S_SQUPD  = 5'd14;
    localparam logic [4:0] S_ACC    = 5'd15;
    localparam logic [4:0] S_UPD    = 5'd16;
    localparam logic [4:0] S_UPD2   = 5'd17;
    localparam logic [4:0] S_SUM    = 5'd18;
    localparam logic [4:0] S_THR    = 5'd19;
    localparam logic [4:0] S_CHK    = 5'd20;
    localparam logic [4:0] S_CLR    = 5'd21;
    localparam logic [4:0] S_READ   = 5'd22;
    localparam logic [4:0] S_READ2  = 5'd23;
    localparam logic [4:0] S_DONE   = 5'd24;

    localparam logic [CNT_CTR_W-1:0] C_SPIN_END = 11'd5;
    localparam logic [CNT_CTR_W-1:0] C_INIT_END = 11'd1023;
    localparam logic [CNT_CTR_W-1:0] C_BINS     = 11'd512;
    localparam logic [CNT_CTR_W-1:0] C_CLR_END  = 11'd511;
    localparam logic [CNT_CTR_W-1:0] C_K_FIRST  = 11'd12;
    localparam logic [CNT_CTR_W-1:0] C_K_LAST   = 11'd1;
    localparam logic [CNT_CTR_W-1:0] C_SQ_LAST  = 11'd4;

    logic [4:0]           state_reg, state_next;
    logic [CNT_CTR_W-1:0] cnt_reg, cnt_next;
    logic                 out_valid_reg, out_valid_next;
    logic [4:0]           op;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign cmd.op    = op;
    assign cmd.cnt   = cnt_reg;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        op         = OP_NOP;
        case (state_reg)
            S_INIT:
            begin
                op = OP_INIT;
                if (cnt_reg == C_INIT_END)
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op         = OP_LOAD;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                cnt_next = '0;
                if ((stat.req inside {REQ_FLIP, REQ_WRITE}) && stat.sub != SUB_NONE)
                    state_next = S_SPIN;
                else if (stat.req == REQ_FLAT)
                    state_next = S_SUM;
                else if (stat.req == REQ_CLEAR)
                    state_next = S_CLR;
                else if (stat.req == REQ_READ)
                    state_next = S_READ;
                else
                    state_next = S_DONE;
            end
            // own spin then four neighbors; last data lands at count 5
            S_SPIN:
            begin
                if (cnt_reg == C_SPIN_END)
                begin
                    state_next = S_DELTA;
                end
                else
                begin
                    op       = OP_SPIN_RD;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_DELTA:
            begin
                op         = OP_DELTA;
                state_next = (stat.req == REQ_WRITE) ? S_WRITE : S_RDI;
            end
            S_WRITE:
            begin
                op         = OP_WRITE;
                state_next = S_DONE;
            end
            S_RDI:
            begin
                op         = OP_RD_GI;
                state_next = S_RDF;
            end
            S_RDF:
            begin
                op         = OP_RD_GF;
                state_next = S_WAITF;
            end
            S_WAITF:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                op = OP_DECIDE;
                if (stat.ge)
                    state_next = S_UPD;
                else if (stat.big)
                    state_next = S_ACC;
                else
                begin
                    cnt_next   = C_K_FIRST;
                    state_next = S_HMUL;
                end
            end
            // Horner series, k = 12 down to 1
            S_HMUL:
            begin
                op         = OP_H_MUL;
                state_next = S_HREC;
            end
            S_HREC:
            begin
                op         = OP_H_REC;
                state_next = S_HFIX;
            end
            S_HFIX:
            begin
                op = OP_H_FIX;
                if (cnt_reg == C_K_LAST)
                begin
                    cnt_next   = '0;
                    state_next = S_SQMUL;
                end
                else
                begin
                    cnt_next   = cnt_reg - 1'b1;
                    state_next = S_HMUL;
                end
            end
            // five squarings
            S_SQMUL:
            begin
                op         = OP_SQ_MUL;
                state_next = S_SQUPD;
            end
            S_SQUPD:
            begin
                op = OP_SQ_UPD;
                if (cnt_reg == C_SQ_LAST)
                begin
                    state_next = S_ACC;
                end
                else
                begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = S_SQMUL;
                end
            end
            S_ACC:
            begin
                op         = OP_ACC;
                state_next = S_UPD;
            end
            S_UPD:
            begin
                op         = OP_UPD;
                state_next = S_UPD2;
            end
            S_UPD2:
            begin
                op         = OP_UPD2;
                state_next = S_DONE;
            end
            // flatness: sum pass, threshold, check pass
            S_SUM:
            begin
                if (cnt_reg == C_BINS)
                begin
                    state_next = S_THR;
                end
                else
                begin
                    op       = OP_SUM_RD;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_THR:
            begin
                op         = OP_THR;
                cnt_next   = '0;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (cnt_reg == C_BINS)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    op       = OP_CHK_RD;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_CLR:
            begin
                op = OP_CLR;
                if (cnt_reg == C_CLR_END)
                    state_next = S_DONE;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_READ:
            begin
                op         = OP_BIN_RD;
                state_next = S_READ2;
            end
            S_READ2:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    op         = OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output valid
    always_comb
    begin
        if (op == OP_OUT)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ sv/wlkfe_dp.sv @@
module wlkfe_dp import wlkfe_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  cmd_t                cmd,
    output stat_t               stat,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [CFG_W-1:0]    cfg_data,
    input  logic [2:0]          req_type,
    input  logic [1:0]          sublattice,
    input  logic [3:0]          site_x,
    input  logic [3:0]          site_y,
    input  logic                spin_value,
    input  logic [31:0]         uniform,
    input  logic [BIN_AW-1:0]   bin_index,
    output logic                accepted,
    output logic signed [E_W-1:0] energy_out,
    output logic [LD_W-1:0]     bin_log_density,
    output logic [CNT_W-1:0]    bin_count,
    output logic                is_flat
);

    // Config and control registers
    logic [CFG_W-1:0]  lmf_reg;
    logic [15:0]       ff_reg;
    logic [E_W-1:0]    energy_reg;
    logic [4:0]        op_d_reg;
    logic [2:0]        sel_d_reg;

    // Latched request
    logic [2:0]        req_reg;
    logic [1:0]        sub_reg;
    logic [3:0]        x_reg, y_reg;
    logic              val_reg;
    logic [31:0]       u_reg;
    logic [BIN_AW-1:0] bidx_reg;

    // Flip datapath
    logic              own_reg;
    logic signed [3:0] nsum_reg;
    logic [E_W-1:0]    enew_reg;
    logic [BIN_AW-1:0] gi_reg, gf_reg, ch_reg;
    logic [LD_W-1:0]   ldi_reg, ldf_reg, ldc_reg;
    logic              acc_reg;
    logic [31:0]       x_arg_reg;
    logic [32:0]       p_reg;
    logic [65:0]       m_reg;
    logic [32:0]       q_reg;
    logic [65:0]       pr_reg;
    logic              sq_act_reg;

    // Flatness
    logic [40:0]       sum_reg;
    logic [31:0]       mean_reg;
    logic [48:0]       thr_reg;
    logic              flat_reg;

    // Result staging
    logic [LD_W-1:0]   res_ld_reg;
    logic [CNT_W-1:0]  res_cnt_reg;

    // RAM ports
    logic                spin_we, spin_wdata, spin_rdata;
    logic [SPIN_AW-1:0]  spin_waddr, spin_raddr, own_addr;
    logic                ld_we, cnt_we;
    logic [BIN_AW-1:0]   ld_waddr, cnt_waddr, bin_raddr;
    logic [LD_W-1:0]     ld_wdata, ld_rdata;
    logic [CNT_W-1:0]    cnt_wdata, cnt_rdata;

    // Combinational helpers
    logic [3:0]          xm, xp, ym, yp;
    logic signed [4:0]   dbl, delta;
    logic signed [E_W:0] e_cur, e_new;
    logic [LD_W-1:0]     dd;
    logic [BIN_AW-1:0]   ch_c;
    logic [LD_W:0]       ld_sum;
    logic [LD_W-1:0]     ld_sat;
    logic [CNT_W-1:0]    cnt_inc;
    logic [3:0]          k;
    logic [32:0]         est0, est1, est2;
    logic [36:0]         ek;
    logic [5:0]          r0, r1;
    logic [31:0]         mean_c, diff;

    function automatic logic [BIN_AW-1:0] bin_of(input logic signed [E_W:0] e);
        logic signed [E_W:0] off;
        logic [BIN_AW-1:0]   b;
        off = e - E_MIN_C;
        if (e == E_MAX_C)
            b = '1;
        else if (e < E_MIN_C)
            b = '0;
        else if (off[E_W:2] > 11'd511)
            b = '1;
        else
            b = off[BIN_AW+1:2];
        return b;
    endfunction

    // Neighbor addressing on the periodic kagome lattice
    assign xm = x_reg - 4'd1;
    assign xp = x_reg + 4'd1;
    assign ym = y_reg - 4'd1;
    assign yp = y_reg + 4'd1;
    assign own_addr = {sub_reg, y_reg, x_reg};

    always_comb
    begin
        spin_raddr = own_addr;
        case (sub_reg)
            2'd0:
            begin
                case (cmd.cnt[2:0])
                    3'd1:    spin_raddr = {2'd1, y_reg, x_reg};
                    3'd2:    spin_raddr = {2'd1, y_reg, xm};
                    3'd3:    spin_raddr = {2'd2, y_reg, x_reg};
                    3'd4:    spin_raddr = {2'd2, ym, x_reg};
                    default: spin_raddr = own_addr;
                endcase
            end
            2'd1:
            begin
                case (cmd.cnt[2:0])
                    3'd1:    spin_raddr = {2'd0, y_reg, x_reg};
                    3'd2:    spin_raddr = {2'd0, y_reg, xp};
                    3'd3:    spin_raddr = {2'd2, y_reg, x_reg};
                    3'd4:    spin_raddr = {2'd2, ym, xp};
                    default: spin_raddr = own_addr;
                endcase
            end
            default:
            begin
                case (cmd.cnt[2:0])
                    3'd1:    spin_raddr = {2'd0, y_reg, x_reg};
                    3'd2:    spin_raddr = {2'd0, yp, x_reg};
                    3'd3:    spin_raddr = {2'd1, y_reg, x_reg};
                    3'd4:    spin_raddr = {2'd1, yp, xm};
                    default: spin_raddr = own_addr;
                endcase
            end
        endcase
    end

    // Energy change of a flip
    assign dbl   = {nsum_reg, 1'b0};
    assign delta = own_reg ? -dbl : dbl;
    assign e_cur = {energy_reg[E_W-1], energy_reg};
    assign e_new = e_cur + {{(E_W-4){delta[4]}}, delta};

    // Acceptance helpers
    assign dd        = ldf_reg - ldi_reg;
    assign stat.req  = req_reg;
    assign stat.sub  = sub_reg;
    assign stat.ge   = (ldi_reg >= ldf_reg);
    assign stat.big  = |dd[LD_W-1:37];
    assign ch_c      = acc_reg ? gf_reg : gi_reg;

    // Division by k: reciprocal estimate, then up to two corrections
    assign k    = cmd.cnt[3:0];
    assign est0 = pr_reg[64:32];
    assign ek   = est0 * k;
    assign r0   = 6'(37'(q_reg) - ek);
    always_comb
    begin
        est1 = est0;
        r1   = r0;
        if (r0 >= {2'd0, k})
        begin
            est1 = est0 + 33'd1;
            r1   = r0 - {2'd0, k};
        end
        est2 = est1;
        if (r1 >= {2'd0, k})
            est2 = est1 + 33'd1;
    end

    // Bin update values
    assign ld_sum  = {1'b0, ldc_reg} + 49'(lmf_reg);
    assign ld_sat  = ld_sum[LD_W] ? LD_MAX : ld_sum[LD_W-1:0];
    assign cnt_inc = (cnt_rdata == CNT_MAX) ? cnt_rdata : cnt_rdata + 32'd1;

    // Flatness helpers
    assign mean_c = sum_reg[40:9];
    assign diff   = (cnt_rdata >= mean_reg) ? cnt_rdata - mean_reg : mean_reg - cnt_rdata;

    // RAM port selection
    always_comb
    begin
        spin_we    = (cmd.op == OP_INIT) || (cmd.op == OP_WRITE)
                     || (cmd.op == OP_UPD && acc_reg);
        spin_waddr = (cmd.op == OP_INIT) ? cmd.cnt[SPIN_AW-1:0] : own_addr;
        if (cmd.op == OP_INIT)
            spin_wdata = 1'b1;
        else if (cmd.op == OP_WRITE)
            spin_wdata = val_reg;
        else
            spin_wdata = ~own_reg;

        case (cmd.op)
            OP_RD_GI:  bin_raddr = gi_reg;
            OP_RD_GF:  bin_raddr = gf_reg;
            OP_UPD:    bin_raddr = ch_c;
            OP_BIN_RD: bin_raddr = bidx_reg;
            default:   bin_raddr = cmd.cnt[BIN_AW-1:0];
        endcase

        ld_we    = (cmd.op == OP_INIT) || (cmd.op == OP_UPD2);
        ld_waddr = (cmd.op == OP_INIT) ? cmd.cnt[BIN_AW-1:0] : ch_reg;
        ld_wdata = (cmd.op == OP_INIT) ? LD_ONE : ld_sat;

        cnt_we    = (cmd.op == OP_INIT) || (cmd.op == OP_CLR) || (cmd.op == OP_UPD2);
        cnt_waddr = (cmd.op == OP_UPD2) ? ch_reg : cmd.cnt[BIN_AW-1:0];
        cnt_wdata = (cmd.op == OP_UPD2) ? cnt_inc : 32'd1;
    end

    wlkfe_ram #(.WIDTH(1), .DEPTH(1 << SPIN_AW)) u_spin_ram (
        .clk   (clk),
        .we    (spin_we),
        .waddr (spin_waddr),
        .wdata (spin_wdata),
        .raddr (spin_raddr),
        .rdata (spin_rdata)
    );

    wlkfe_ram #(.WIDTH(LD_W), .DEPTH(1 << BIN_AW)) u_ld_ram (
        .clk   (clk),
        .we    (ld_we),
        .waddr (ld_waddr),
        .wdata (ld_wdata),
        .raddr (bin_raddr),
        .rdata (ld_rdata)
    );

    wlkfe_ram #(.WIDTH(CNT_W), .DEPTH(1 << BIN_AW)) u_cnt_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .raddr (bin_raddr),
        .rdata (cnt_rdata)
    );

    // Control registers: config, energy, read pipeline tags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lmf_reg    <= Q32_ONE;
            ff_reg     <= FF_RESET;
            energy_reg <= E_RESET;
            op_d_reg   <= OP_NOP;
            sel_d_reg  <= '0;
        end
        else
        begin
            op_d_reg  <= cmd.op;
            sel_d_reg <= cmd.cnt[2:0];
            if (cfg_we && cfg_index == REG_LMF)
                lmf_reg <= cfg_data;
            if (cfg_we && cfg_index == REG_FF)
                ff_reg <= cfg_data[15:0];
            if ((cmd.op == OP_WRITE && own_reg != val_reg) || (cmd.op == OP_UPD && acc_reg))
                energy_reg <= enew_reg;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                req_reg     <= req_type;
                sub_reg     <= sublattice;
                x_reg       <= site_x;
                y_reg       <= site_y;
                val_reg     <= spin_value;
                u_reg       <= uniform;
                bidx_reg    <= bin_index;
                acc_reg     <= 1'b0;
                flat_reg    <= 1'b0;
                sum_reg     <= '0;
                res_ld_reg  <= '0;
                res_cnt_reg <= '0;
            end
            OP_DELTA:
            begin
                enew_reg <= e_new[E_W-1:0];
                gi_reg   <= bin_of(e_cur);
                gf_reg   <= bin_of(e_new);
            end
            OP_DECIDE:
            begin
                acc_reg   <= stat.ge;
                x_arg_reg <= dd[36:5];
                p_reg     <= stat.big ? 33'd0 : Q32_ONE;
            end
            OP_H_MUL:
            begin
                m_reg <= 66'(x_arg_reg * p_reg);
            end
            OP_H_REC:
            begin
                q_reg  <= m_reg[64:32];
                pr_reg <= m_reg[64:32] * recip(k);
            end
            OP_H_FIX:
            begin
                p_reg <= Q32_ONE - est2;
            end
            OP_SQ_MUL:
            begin
                m_reg      <= p_reg * p_reg;
                sq_act_reg <= ~p_reg[32];
            end
            OP_SQ_UPD:
            begin
                if (sq_act_reg)
                    p_reg <= {1'b0, m_reg[63:32]};
            end
            OP_ACC:
            begin
                acc_reg <= ({1'b0, u_reg} < p_reg);
            end
            OP_UPD:
            begin
                ch_reg  <= ch_c;
                ldc_reg <= acc_reg ? ldf_reg : ldi_reg;
            end
            OP_UPD2:
            begin
                res_ld_reg  <= ld_sat;
                res_cnt_reg <= cnt_inc;
            end
            OP_THR:
            begin
                mean_reg <= mean_c;
                thr_reg  <= (17'h10000 - {1'b0, ff_reg}) * mean_c;
                flat_reg <= 1'b1;
            end
            OP_OUT:
            begin
                accepted        <= acc_reg;
                energy_out      <= energy_reg;
                bin_log_density <= res_ld_reg;
                bin_count       <= res_cnt_reg;
                is_flat         <= flat_reg;
            end
            default:
            begin
            end
        endcase

        // Consume RAM data in the cycle after the read
        case (op_d_reg)
            OP_SPIN_RD:
            begin
                if (sel_d_reg == 3'd0)
                begin
                    own_reg  <= spin_rdata;
                    nsum_reg <= '0;
                end
                else
                begin
                    nsum_reg <= nsum_reg + (spin_rdata ? 4'sd1 : -4'sd1);
                end
            end
            OP_RD_GI:
            begin
                ldi_reg <= ld_rdata;
            end
            OP_RD_GF:
            begin
                ldf_reg <= ld_rdata;
            end
            OP_SUM_RD:
            begin
                sum_reg <= sum_reg + 41'(cnt_rdata);
            end
            OP_CHK_RD:
            begin
                if ({1'b0, diff, 16'h0000} > thr_reg)
                    flat_reg <= 1'b0;
            end
            OP_BIN_RD:
            begin
                res_ld_reg  <= ld_rdata;
                res_cnt_reg <= cnt_rdata;
            end
            default:
            begin
            end
        endcase
    end

endmodule

@@ bench/wlkfe_checker.sv @@
module wlkfe_checker import wlkfe_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  logic [2:0]            req_type,
    input  logic [1:0]            sublattice,
    input  logic [3:0]            site_x,
    input  logic [3:0]            site_y,
    input  logic                  spin_value,
    input  logic [31:0]           uniform,
    input  logic [BIN_AW-1:0]     bin_index,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  logic                  accepted,
    input  logic signed [E_W-1:0] energy_out,
    input  logic [LD_W-1:0]       bin_log_density,
    input  logic [CNT_W-1:0]      bin_count,
    input  logic                  is_flat,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data,
    output int                    fail_count,
    output int                    pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NBINS = 512;

    typedef struct {
        logic             acc;
        logic [E_W-1:0]   energy;
        logic [LD_W-1:0]  ld;
        logic [CNT_W-1:0] cnt;
        logic             flat;
    } flip_result_t;

    // mirrored lattice, tables and registers
    logic             spin_mirror [3][256];
    logic [LD_W-1:0]  ld_mirror [NBINS];
    logic [CNT_W-1:0] cnt_mirror [NBINS];
    int               energy_mirror;
    logic [32:0]      lmf_mirror;
    logic [15:0]      ff_mirror;

    flip_result_t awaited_results [$];

    assign pending = awaited_results.size();

    function automatic int spin_sign(int sub, logic [3:0] x, logic [3:0] y);
        return spin_mirror[sub][{y, x}] ? 1 : -1;
    endfunction

    // energy change for flipping one site, periodic in both directions
    function automatic int site_delta(int sub, logic [3:0] x, logic [3:0] y);
        int sum;
        logic [3:0] xm, xp, ym, yp;
        xm = x - 4'd1;
        xp = x + 4'd1;
        ym = y - 4'd1;
        yp = y + 4'd1;
        if (sub == 0)
            sum = spin_sign(1, x, y) + spin_sign(1, xm, y) + spin_sign(2, x, y)
                + spin_sign(2, x, ym);
        else if (sub == 1)
            sum = spin_sign(0, x, y) + spin_sign(0, xp, y) + spin_sign(2, x, y)
                + spin_sign(2, xp, ym);
        else
            sum = spin_sign(0, x, y) + spin_sign(0, x, yp) + spin_sign(1, x, y)
                + spin_sign(1, xm, yp);
        return -2 * spin_sign(sub, x, y) * sum;
    endfunction

    function automatic int energy_bin(int e);
        int idx;
        if (e == 1536) return NBINS - 1;
        if (e < -512) return 0;
        idx = (e + 512) / 4;
        if (idx >= NBINS) idx = NBINS - 1;
        return idx;
    endfunction

    // exp(-d) by a 12-term Horner series on d/32, then squared five times
    function automatic logic [63:0] decay_prob(logic [63:0] d);
        logic [63:0] x, p;
        if (d >= (64'd32 << 32)) return 64'd0;
        x = d >> 5;
        p = 64'h1_0000_0000;
        for (int k = 12; k >= 1; k--)
            p = 64'h1_0000_0000 - (((x * p) >> 32) / k);
        for (int k = 0; k < 5; k++)
            if (p < 64'h1_0000_0000) p = (p * p) >> 32;
        return p;
    endfunction

    function automatic flip_result_t predict_request();
        flip_result_t r;
        int d, gi, gf, ch;
        logic [63:0] s, sum, mean, h, diff;
        r.acc = 0;
        r.ld = '0;
        r.cnt = '0;
        r.flat = 0;
        if (req_type == REQ_FLIP && sublattice != SUB_NONE) begin
            d = site_delta(sublattice, site_x, site_y);
            gi = energy_bin(energy_mirror);
            gf = energy_bin(energy_mirror + d);
            if (ld_mirror[gi] >= ld_mirror[gf])
                r.acc = 1;
            else
                r.acc = {32'd0, uniform} <
                        decay_prob({16'd0, ld_mirror[gf] - ld_mirror[gi]});
            if (r.acc) begin
                spin_mirror[sublattice][{site_y, site_x}] ^= 1'b1;
                energy_mirror += d;
                ch = gf;
            end else begin
                ch = gi;
            end
            s = {16'd0, ld_mirror[ch]} + {31'd0, lmf_mirror};
            ld_mirror[ch] = (s > {16'd0, LD_MAX}) ? LD_MAX : s[LD_W-1:0];
            if (cnt_mirror[ch] != CNT_MAX) cnt_mirror[ch]++;
            r.ld = ld_mirror[ch];
            r.cnt = cnt_mirror[ch];
        end else if (req_type == REQ_WRITE && sublattice != SUB_NONE) begin
            if (spin_mirror[sublattice][{site_y, site_x}] != spin_value) begin
                energy_mirror += site_delta(sublattice, site_x, site_y);
                spin_mirror[sublattice][{site_y, site_x}] = spin_value;
            end
        end else if (req_type == REQ_FLAT) begin
            r.flat = 1;
            sum = 0;
            foreach (cnt_mirror[i]) sum += cnt_mirror[i];
            mean = sum / NBINS;
            foreach (cnt_mirror[i]) begin
                h = cnt_mirror[i];
                diff = (h >= mean) ? h - mean : mean - h;
                if (diff * 65536 > (64'd65536 - ff_mirror) * mean) r.flat = 0;
            end
        end else if (req_type == REQ_CLEAR) begin
            foreach (cnt_mirror[i]) cnt_mirror[i] = 1;
        end else if (req_type == REQ_READ) begin
            r.ld = ld_mirror[bin_index];
            r.cnt = cnt_mirror[bin_index];
        end
        r.energy = energy_mirror[E_W-1:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        flip_result_t exp_r;
        if (!rst_n) begin
            foreach (spin_mirror[s, i]) spin_mirror[s][i] = 1'b1;
            foreach (ld_mirror[i]) ld_mirror[i] = LD_ONE;
            foreach (cnt_mirror[i]) cnt_mirror[i] = 1;
            energy_mirror = 1536;
            lmf_mirror = Q32_ONE;
            ff_mirror = FF_RESET;
            awaited_results.delete();
            fail_count = 0;
        end else begin
            // register writes
            if (cfg_we) begin
                if (cfg_index == REG_LMF) lmf_mirror = cfg_data;
                else ff_mirror = cfg_data[15:0];
            end
            // accepted request
            if (in_valid && !in_stall)
                awaited_results = {awaited_results, predict_request()};
            // accepted result
            if (out_valid && !out_stall) begin
                if (awaited_results.size() == 0) begin
                    $error("result with no request outstanding");
                    fail_count++;
                end else begin
                    exp_r = awaited_results.pop_front();
                    if (accepted !== exp_r.acc) begin
                        $error("accepted: expected %0d actual %0d", exp_r.acc, accepted);
                        fail_count++;
                    end
                    if (energy_out !== exp_r.energy) begin
                        $error("energy_out: expected %0d actual %0d",
                               $signed(exp_r.energy), energy_out);
                        fail_count++;
                    end
                    if (bin_log_density !== exp_r.ld) begin
                        $error("bin_log_density: expected %h actual %h",
                               exp_r.ld, bin_log_density);
                        fail_count++;
                    end
                    if (bin_count !== exp_r.cnt) begin
                        $error("bin_count: expected %0d actual %0d", exp_r.cnt, bin_count);
                        fail_count++;
                    end
                    if (is_flat !== exp_r.flat) begin
                        $error("is_flat: expected %0d actual %0d", exp_r.flat, is_flat);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

@@ bench/wang_landau_kagome_flip_engine_unit_tb.sv @@
module wang_landau_kagome_flip_engine_unit_tb;
    import wlkfe_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 12000000;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic [2:0]            req_type;
    logic [1:0]            sublattice;
    logic [3:0]            site_x;
    logic [3:0]            site_y;
    logic                  spin_value;
    logic [31:0]           uniform;
    logic [BIN_AW-1:0]     bin_index;
    logic                  out_valid;
    logic                  out_stall;
    logic                  accepted;
    logic signed [E_W-1:0] energy_out;
    logic [LD_W-1:0]       bin_log_density;
    logic [CNT_W-1:0]      bin_count;
    logic                  is_flat;
    logic                  cfg_we;
    logic                  cfg_index;
    logic [CFG_W-1:0]      cfg_data;
    int                    fail_count;
    int                    pending;
    int                    cycles = 0;
    bit                    quiet;

    wang_landau_kagome_flip_engine_unit uut (.*);
    wlkfe_checker checker_i (.*);

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // cycle limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // result side back-pressure
    always @(posedge clk)
        out_stall <= !quiet && ($urandom_range(0, 99) < 6);

    task automatic send_request(logic [2:0] rq, logic [1:0] sb, logic [3:0] x, logic [3:0] y,
                                logic v, logic [31:0] u, logic [8:0] b);
        if (!quiet && $urandom_range(0, 99) < 6) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        req_type   <= rq;
        sublattice <= sb;
        site_x     <= x;
        site_y     <= y;
        spin_value <= v;
        uniform    <= u;
        bin_index  <= b;
        in_valid   <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // mostly flips and writes on live sublattices, a little of everything else
    task automatic random_request();
        int pick;
        logic [2:0] rq;
        logic [1:0] sb;
        pick = $urandom_range(0, 999);
        if (pick < 520)      rq = REQ_FLIP;
        else if (pick < 770) rq = REQ_WRITE;
        else if (pick < 780) rq = REQ_FLAT;
        else if (pick < 788) rq = REQ_CLEAR;
        else if (pick < 970) rq = REQ_READ;
        else                 rq = 3'($urandom_range(5, 7));
        sb = ($urandom_range(0, 99) < 4) ? SUB_NONE : 2'($urandom_range(0, 2));
        send_request(rq, sb, 4'($urandom), 4'($urandom), 1'($urandom), $urandom,
                     9'($urandom));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    logic [32:0] lmf_set [6];
    logic [15:0] ff_set  [6];

    initial
    begin
        rst_n = 0;
        in_valid = 0;
        req_type = '0;
        sublattice = '0;
        site_x = '0;
        site_y = '0;
        spin_value = 0;
        uniform = '0;
        bin_index = '0;
        cfg_we = 0;
        cfg_index = REG_LMF;
        cfg_data = '0;
        quiet = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, every request, unused codes
        send_request(REQ_READ, 0, 0, 0, 0, 0, 9'd0);
        send_request(REQ_READ, 0, 0, 0, 0, 0, 9'd511);
        send_request(REQ_FLAT, 0, 0, 0, 0, 0, 0);
        send_request(REQ_FLIP, 0, 0, 0, 0, 32'hFFFF_FFFF, 0);
        send_request(REQ_FLIP, 1, 15, 15, 0, 32'h0, 0);
        send_request(REQ_FLIP, 2, 15, 0, 0, 32'h8000_0000, 0);
        send_request(REQ_FLIP, SUB_NONE, 3, 3, 0, 0, 0);
        send_request(REQ_WRITE, 0, 7, 8, 1, 0, 0);
        send_request(REQ_WRITE, 0, 7, 8, 0, 0, 0);
        send_request(REQ_WRITE, 1, 0, 15, 0, 0, 0);
        send_request(REQ_WRITE, 2, 15, 15, 0, 0, 0);
        send_request(REQ_WRITE, SUB_NONE, 1, 1, 0, 0, 0);
        send_request(REQ_FLIP, 0, 7, 8, 0, 32'h0000_0001, 0);
        send_request(REQ_FLIP, 1, 0, 15, 0, 32'hFFFF_FFFF, 0);
        send_request(REQ_FLAT, 0, 0, 0, 0, 0, 0);
        send_request(REQ_CLEAR, 0, 0, 0, 0, 0, 0);
        send_request(REQ_FLAT, 0, 0, 0, 0, 0, 0);
        send_request(REQ_READ, 0, 0, 0, 0, 0, 9'd511);
        send_request(3'd5, 0, 0, 0, 0, 0, 0);
        send_request(3'd7, 3, 15, 15, 1, 32'hFFFF_FFFF, 9'h1FF);
        drain();

        // register settings per phase, extremes included
        lmf_set = '{33'h1_0000_0000, 33'd1, 33'h1_FFFF_FFFF, 33'd0, 33'h0_8000_0000,
                    33'h1_2345_6789};
        ff_set  = '{16'd52429, 16'd0, 16'd65535, 16'd32768, 16'd60000, 16'd52429};
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(REG_LMF, lmf_set[ph]);
            write_reg(REG_FF, ff_set[ph]);
            for (int i = 0; i < 330; i++) begin
                quiet = (ph == 1 && i >= 50 && i < 250);
                random_request();
                // hold off until every result is back
                if (ph == 2 && i == 150) drain();
            end
            quiet = 0;
            drain();
        end

        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
